// ===== design/pie_pkg.sv =====
// Shared types, codes and helpers for the postfix integer evaluator.
// No dependencies; imported by every module of the block.
package pie_pkg;

  localparam int DATA_W          = 32;
  localparam int FUNC_W          = 3;
  localparam int STATUS_W        = 2;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Token function codes as seen on the input channel
  localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SUB    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MUL    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DIV    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_MOD    = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_FINISH = 3'd6;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OVER  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_DIVZ  = 2'd3;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_MOD,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] operand;
  } token_t;

  typedef enum logic [1:0] {
    EX_IDLE,
    EX_OPER,
    EX_DIV
  } exec_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_FIX
  } div_state_t;

  typedef struct packed {
    logic start;
    logic want_rem;
  } div_ctl_t;

  // Keep only the first error since the last finish
  function automatic logic [STATUS_W-1:0] latch_err(input logic [STATUS_W-1:0] cur,
                                                     input logic [STATUS_W-1:0] code);
    return (cur == STAT_OK) ? code : cur;
  endfunction

endpackage

// ===== design/pie_front.sv =====
// Front end: takes tokens from the input channel, decodes the function code
// and enqueues them. Depends on pie_pkg.
module pie_front (
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [pie_pkg::FUNC_W-1:0]  in_tuser,
  input  logic [pie_pkg::DATA_W-1:0]  in_tdata,
  input  logic                        q_full,
  output logic                        q_push,
  output pie_pkg::token_t             q_data
);
  import pie_pkg::*;

  logic op_known;
  op_t  op;

  always_comb begin
    op_known = 1'b1;
    case (in_tuser)
      FUNC_PUSH:   op = OP_PUSH;
      FUNC_ADD:    op = OP_ADD;
      FUNC_SUB:    op = OP_SUB;
      FUNC_MUL:    op = OP_MUL;
      FUNC_DIV:    op = OP_DIV;
      FUNC_MOD:    op = OP_MOD;
      FUNC_FINISH: op = OP_FINISH;
      default: begin
        // unused code: taken and dropped
        op       = OP_PUSH;
        op_known = 1'b0;
      end
    endcase
  end

  assign in_tready      = !q_full;
  assign q_push         = in_tvalid && !q_full && op_known;
  assign q_data.op      = op;
  assign q_data.operand = in_tdata;

endmodule

// ===== design/pie_fifo.sv =====
// Small token queue between front end and execution unit.
// Depends on pie_pkg (token_t).
module pie_fifo #(
  parameter int DEPTH = pie_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pie_pkg::token_t wr_data,
  output logic            full,
  input  logic            pop,
  output pie_pkg::token_t rd_data,
  output logic            empty
);
  import pie_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  token_t          data_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = data_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== design/pie_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, signed truncating
// quotient or remainder. Depends on pie_pkg.
module pie_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pie_pkg::div_ctl_t          ctl,
  input  logic [pie_pkg::DATA_W-1:0] lhs,
  input  logic [pie_pkg::DATA_W-1:0] rhs,
  output logic                       done,
  output logic [pie_pkg::DATA_W-1:0] result
);
  import pie_pkg::*;

  localparam int NW = $clog2(DATA_W);

  div_state_t        state_r, state_nxt;
  logic [NW-1:0]     cnt_r, cnt_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] den_r, den_nxt;
  logic              a_neg_r, a_neg_nxt;
  logic              b_neg_r, b_neg_nxt;
  logic              rem_sel_r, rem_sel_nxt;
  logic              done_r, done_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic [DATA_W:0]   trial;

  assign trial  = {rem_r, quo_r[DATA_W-1]} - {1'b0, den_r};
  assign done   = done_r;
  assign result = res_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    den_nxt     = den_r;
    a_neg_nxt   = a_neg_r;
    b_neg_nxt   = b_neg_r;
    rem_sel_nxt = rem_sel_r;
    res_nxt     = res_r;
    done_nxt    = 1'b0;
    case (state_r)
      DV_IDLE: begin
        if (ctl.start) begin
          a_neg_nxt   = lhs[DATA_W-1];
          b_neg_nxt   = rhs[DATA_W-1];
          quo_nxt     = lhs[DATA_W-1] ? -lhs : lhs;
          den_nxt     = rhs[DATA_W-1] ? -rhs : rhs;
          rem_nxt     = '0;
          cnt_nxt     = '0;
          rem_sel_nxt = ctl.want_rem;
          state_nxt   = DV_RUN;
        end
      end
      DV_RUN: begin
        if (!trial[DATA_W]) begin
          rem_nxt = trial[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[DATA_W-2:0], quo_r[DATA_W-1]};
          quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == NW'(DATA_W - 1)) begin
          state_nxt = DV_FIX;
        end
      end
      DV_FIX: begin
        // sign fix-up: remainder follows dividend, quotient follows sign xor
        if (rem_sel_r) begin
          res_nxt = a_neg_r ? -rem_r : rem_r;
        end else begin
          res_nxt = (a_neg_r ^ b_neg_r) ? -quo_r : quo_r;
        end
        done_nxt  = 1'b1;
        state_nxt = DV_IDLE;
      end
      default: begin
        state_nxt = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    den_r     <= den_nxt;
    a_neg_r   <= a_neg_nxt;
    b_neg_r   <= b_neg_nxt;
    rem_sel_r <= rem_sel_nxt;
    res_r     <= res_nxt;
  end

endmodule

// ===== design/pie_exec.sv =====
// Execution unit: operand stack memory with cached top entry, ALU, divider
// handshake and output register. Depends on pie_pkg; drives pie_div.
module pie_exec #(
  parameter int STACK_DEPTH = pie_pkg::STACK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  pie_pkg::token_t              q_data,
  output logic                         q_pop,
  output pie_pkg::div_ctl_t            div_ctl,
  output logic [pie_pkg::DATA_W-1:0]   div_lhs,
  output logic [pie_pkg::DATA_W-1:0]   div_rhs,
  input  logic                         div_done,
  input  logic [pie_pkg::DATA_W-1:0]   div_result,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [pie_pkg::DATA_W-1:0]   out_tdata,
  output logic [pie_pkg::STATUS_W-1:0] out_tuser
);
  import pie_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  logic [DATA_W-1:0]   stack_r [STACK_DEPTH];
  logic [DATA_W-1:0]   rd_data_r;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [DATA_W-1:0]   mem_wd;
  logic [AW-1:0]       rd_addr;

  exec_state_t         state_r, state_nxt;
  logic [SPW-1:0]      sp_r, sp_nxt;
  logic [SPW-1:0]      sp_m2;
  logic [STATUS_W-1:0] err_r, err_nxt;
  logic [DATA_W-1:0]   tos_r, tos_nxt;
  op_t                 op_r, op_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_value_r, out_value_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic [DATA_W-1:0]   lhs, rhs, mul_lo;
  logic                commit;
  logic [DATA_W-1:0]   commit_val;

  assign sp_m2   = sp_r - SPW'(2);
  assign rd_addr = sp_m2[AW-1:0];
  assign lhs     = rd_data_r;
  assign rhs     = tos_r;
  assign mul_lo  = lhs * rhs;
  assign div_lhs = lhs;
  assign div_rhs = rhs;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  always_comb begin
    state_nxt        = state_r;
    sp_nxt           = sp_r;
    err_nxt          = err_r;
    tos_nxt          = tos_r;
    op_nxt           = op_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_value_nxt    = out_value_r;
    out_status_nxt   = out_status_r;
    q_pop            = 1'b0;
    div_ctl.start    = 1'b0;
    div_ctl.want_rem = (op_r == OP_MOD);
    commit           = 1'b0;
    commit_val       = '0;
    mem_we           = 1'b0;
    mem_wa           = sp_r[AW-1:0];
    mem_wd           = q_data.operand;

    case (state_r)
      EX_IDLE: begin
        if (!q_empty) begin
          case (q_data.op)
            OP_PUSH: begin
              q_pop = 1'b1;
              if (sp_r == SPW'(STACK_DEPTH)) begin
                err_nxt = latch_err(err_r, STAT_OVER);
              end else begin
                mem_we  = 1'b1;
                tos_nxt = q_data.operand;
                sp_nxt  = sp_r + 1'b1;
              end
            end
            OP_FINISH: begin
              if (!out_valid_r || out_tready) begin
                q_pop         = 1'b1;
                out_valid_nxt = 1'b1;
                if (sp_r == '0) begin
                  out_value_nxt  = '0;
                  out_status_nxt = latch_err(err_r, STAT_UNDER);
                end else begin
                  out_value_nxt  = tos_r;
                  out_status_nxt = err_r;
                end
                sp_nxt  = '0;
                err_nxt = STAT_OK;
              end
            end
            default: begin
              // binary operator: second entry is read from memory this cycle
              q_pop = 1'b1;
              if (sp_r < SPW'(2)) begin
                err_nxt = latch_err(err_r, STAT_UNDER);
              end else begin
                op_nxt    = q_data.op;
                state_nxt = EX_OPER;
              end
            end
          endcase
        end
      end
      EX_OPER: begin
        case (op_r)
          OP_ADD: begin
            commit     = 1'b1;
            commit_val = lhs + rhs;
          end
          OP_SUB: begin
            commit     = 1'b1;
            commit_val = lhs - rhs;
          end
          OP_MUL: begin
            commit     = 1'b1;
            commit_val = mul_lo;
          end
          default: begin
            if (rhs == '0) begin
              err_nxt    = latch_err(err_r, STAT_DIVZ);
              commit     = 1'b1;
              commit_val = '0;
            end else begin
              div_ctl.start = 1'b1;
              state_nxt     = EX_DIV;
            end
          end
        endcase
      end
      EX_DIV: begin
        if (div_done) begin
          commit     = 1'b1;
          commit_val = div_result;
        end
      end
      default: begin
        state_nxt = EX_IDLE;
      end
    endcase

    // operator result replaces the two top entries
    if (commit) begin
      mem_we    = 1'b1;
      mem_wa    = sp_m2[AW-1:0];
      mem_wd    = commit_val;
      tos_nxt   = commit_val;
      sp_nxt    = sp_r - 1'b1;
      state_nxt = EX_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= EX_IDLE;
      sp_r        <= '0;
      err_r       <= STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r        <= tos_nxt;
    op_r         <= op_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_r[mem_wa] <= mem_wd;
    end
    rd_data_r <= stack_r[rd_addr];
  end

endmodule

// ===== design/postfix_int_evaluator_top.sv =====
// Top level of the postfix integer evaluator.
// Depends on pie_pkg, pie_front, pie_fifo, pie_exec and pie_div.
//
// Usage:
//   Input channel (in_*): one token per request. in_tuser carries the function
//   code (push, add, sub, mul, div, mod, finish); in_tdata carries the signed
//   operand, used by push only. Code 7 is taken and dropped.
//   Output channel (out_*): one request per finish token. out_tdata is the top
//   of the stack (zero if empty), out_tuser the sticky status (ok, underflow,
//   overflow, divide by zero). The stack and status clear after each finish.
// Timing:
//   Tokens land in a small queue, so the input side keeps taking requests
//   while the execution unit is busy or the output is stalled, until the
//   queue fills. Push and finish run in the idle state; add/sub/mul also
//   pass the operate state (second stack entry comes from a registered
//   memory read); div/mod then wait in the divide state for the divider, one
//   quotient bit per cycle (32 steps plus load, sign fix-up, write-back).
//   A finish token is taken once no result is held; its result is registered.
// Reset (rst_n low, synchronous): empties the queue and stack, clears status
//   and drops any pending result. Stack contents are not cleared.
// Stall: a held output keeps its data; further finish tokens wait in the
//   queue, and in_tready drops once the queue is full.
module postfix_int_evaluator_top #(
  parameter int STACK_DEPTH = pie_pkg::STACK_DEPTH_DEF,
  parameter int QUEUE_DEPTH = pie_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [pie_pkg::FUNC_W-1:0]   in_tuser,   // [2:0] func
  input  logic [pie_pkg::DATA_W-1:0]   in_tdata,   // [31:0] operand
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [pie_pkg::DATA_W-1:0]   out_tdata,  // [31:0] value
  output logic [pie_pkg::STATUS_W-1:0] out_tuser   // [1:0] status
);
  import pie_pkg::*;

  // front end to queue
  logic     q_push, q_full;
  token_t   q_wr_data;
  // queue to execution unit
  logic     q_pop, q_empty;
  token_t   q_rd_data;
  // execution unit to divider
  div_ctl_t          div_ctl;
  logic [DATA_W-1:0] div_lhs, div_rhs, div_result;
  logic              div_done;

  pie_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  pie_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  pie_exec #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_rd_data),
    .q_pop      (q_pop),
    .div_ctl    (div_ctl),
    .div_lhs    (div_lhs),
    .div_rhs    (div_rhs),
    .div_done   (div_done),
    .div_result (div_result),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // divider shared by div and mod
  pie_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (div_ctl),
    .lhs    (div_lhs),
    .rhs    (div_rhs),
    .done   (div_done),
    .result (div_result)
  );

endmodule

// ===== design/pie_chk.sv =====
// Port-level checker for the postfix evaluator top level, with its bind.
// Depends on postfix_int_evaluator_top (bind target) and pie_pkg.
module pie_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [pie_pkg::DATA_W-1:0]   out_tdata,
  input logic [pie_pkg::STATUS_W-1:0] out_tuser
);
  import pie_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // reset drops pending results and empties the queue
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("state not cleared by reset");

  // queue fills only through accepted requests
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid && in_tready))
    else $error("in_tready fell without an accepted request");

  // a presented result carries no unknown bits
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !$isunknown({out_tdata, out_tuser}))
    else $error("result has unknown bits");

endmodule

bind postfix_int_evaluator_top pie_chk u_pie_chk (.*);

// ===== verif/tb_postfix_int_evaluator_top.sv =====
// Self-checking testbench for postfix_int_evaluator_top: token requests in,
// finish results checked against a stack evaluator kept inside the bench.
// Depends on pie_pkg and the design files; needs nothing else.
module tb_postfix_int_evaluator_top;
  import pie_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;

  typedef logic [FUNC_W-1:0] func_t;

  // Code 7 is not a token; the block drops it
  localparam func_t FUNC_RSVD = 3'd7;

  // Result-side ready behavior
  localparam int SINK_FREE   = 0;
  localparam int SINK_RANDOM = 1;
  localparam int SINK_HEAVY  = 2;

  typedef struct {
    logic [DATA_W-1:0]   value;
    logic [STATUS_W-1:0] status;
  } result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [FUNC_W-1:0]   in_tuser;   // [2:0] func
  logic [DATA_W-1:0]   in_tdata;   // [31:0] operand
  logic                out_tvalid;
  logic                out_tready;
  logic [DATA_W-1:0]   out_tdata;  // [31:0] value
  logic [STATUS_W-1:0] out_tuser;  // [1:0] status

  // Evaluator state mirrored in the bench
  logic [DATA_W-1:0]   calc_stack [DEPTH];
  int unsigned         calc_sp;
  logic [STATUS_W-1:0] calc_err;

  result_t     pending_results[$];
  int unsigned tokens_sent;
  int unsigned fail_count;
  bit          gaps_on   = 1'b1;
  int          sink_mode = SINK_RANDOM;

  postfix_int_evaluator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #30_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [DATA_W-1:0] signed_quotient(input logic [DATA_W-1:0] num,
                                                        input logic [DATA_W-1:0] den,
                                                        input bit want_rem);
    logic [DATA_W-1:0] mag_n, mag_d, q, r;
    mag_n = num[DATA_W-1] ? -num : num;
    mag_d = den[DATA_W-1] ? -den : den;
    q = mag_n / mag_d;
    r = mag_n % mag_d;
    // truncation toward zero: remainder follows the dividend's sign
    if (want_rem) return num[DATA_W-1] ? -r : r;
    return (num[DATA_W-1] ^ den[DATA_W-1]) ? -q : q;
  endfunction

  // first error since the last finish wins
  function automatic void raise_err(input logic [STATUS_W-1:0] code);
    if (calc_err == STAT_OK) calc_err = code;
  endfunction

  function automatic void eval_token(input func_t fn, input logic [DATA_W-1:0] opnd);
    logic [DATA_W-1:0] lhs, rhs, res;
    result_t r;
    case (fn)
      FUNC_PUSH: begin
        if (calc_sp >= DEPTH) begin
          raise_err(STAT_OVER);
        end else begin
          calc_stack[calc_sp] = opnd;
          calc_sp++;
        end
      end
      FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV, FUNC_MOD: begin
        if (calc_sp < 2) begin
          raise_err(STAT_UNDER);
        end else begin
          rhs = calc_stack[calc_sp-1];
          lhs = calc_stack[calc_sp-2];
          calc_sp -= 2;
          case (fn)
            FUNC_ADD: res = lhs + rhs;
            FUNC_SUB: res = lhs - rhs;
            FUNC_MUL: res = lhs * rhs;
            default: begin
              if (rhs == '0) begin
                raise_err(STAT_DIVZ);
                res = '0;
              end else begin
                res = signed_quotient(lhs, rhs, fn == FUNC_MOD);
              end
            end
          endcase
          calc_stack[calc_sp] = res;
          calc_sp++;
        end
      end
      FUNC_FINISH: begin
        r.value = '0;
        if (calc_sp == 0) raise_err(STAT_UNDER);
        else r.value = calc_stack[calc_sp-1];
        r.status = calc_err;
        pending_results.insert(pending_results.size(), r);
        calc_sp  = 0;
        calc_err = STAT_OK;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  // mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [DATA_W-1:0] rand_operand();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      3:       return '1;
      4:       return 32'd1;
      5, 6, 7: return $urandom_range(0, 40) - 20;
      default: return $urandom();
    endcase
  endfunction

  function automatic func_t rand_arith();
    return func_t'(FUNC_ADD + $urandom_range(0, 4));
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver and result checker
  // ---------------------------------------------------------------------------
  // valid is only lowered ahead of a gap, so back-to-back requests keep it high
  task automatic send_token(input func_t fn, input logic [DATA_W-1:0] opnd);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= opnd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    eval_token(fn, opnd);
    if (fn != FUNC_RSVD) tokens_sent++;
  endtask

  // hold off new requests until every result is back
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %h status %0d", out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.value) begin
          $error("value: expected %h, actual %h", want.value, out_tdata);
          fail_count++;
        end
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // ready pattern follows sink_mode
  initial begin : result_sink
    int unsigned run, hold;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      out_tready <= 1'b1;
      case (sink_mode)
        SINK_FREE:  run = 1;
        SINK_HEAVY: run = $urandom_range(1, 3);
        default:    run = $urandom_range(1, 12);
      endcase
      repeat (run) @(posedge clk);
      hold = 0;
      if (sink_mode == SINK_HEAVY) begin
        hold = $urandom_range(10, 60);
      end else if (sink_mode == SINK_RANDOM) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: hold = 0;
          9:             hold = $urandom_range(5, 50);
          default:       hold = $urandom_range(1, 4);
        endcase
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus building blocks
  // ---------------------------------------------------------------------------
  // Well-formed expression with random content; a few overfill the stack.
  task automatic send_expression();
    int unsigned cap, len, depth, i;
    if ($urandom_range(0, 19) == 0) cap = DEPTH + $urandom_range(1, 3);
    else if ($urandom_range(0, 3) == 0) cap = $urandom_range(2, DEPTH);
    else cap = $urandom_range(2, 5);
    len   = $urandom_range(1, 2 * cap);
    depth = 0;
    if (cap > DEPTH) begin
      for (i = 0; i < cap; i++) send_token(FUNC_PUSH, rand_operand());
      depth = DEPTH;
    end
    for (i = 0; i < len; i++) begin
      if (depth < 2 || (depth < cap && $urandom_range(0, 1) == 1)) begin
        send_token(FUNC_PUSH, rand_operand());
        if (depth < DEPTH) depth++;
      end else begin
        send_token(rand_arith(), $urandom());
        depth--;
      end
    end
    while (depth > 1) begin
      send_token(rand_arith(), $urandom());
      depth--;
    end
    send_token(FUNC_FINISH, $urandom());
  endtask

  // Arbitrary codes, reserved code included; may leave the stack dirty.
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 6);
    repeat (n) send_token(func_t'($urandom_range(0, 7)), rand_operand());
    if ($urandom_range(0, 1) == 1) send_token(FUNC_FINISH, $urandom());
  endtask

  task automatic run_token_mix(input int unsigned count);
    int unsigned stop_at;
    stop_at = tokens_sent + count;
    while (tokens_sent < stop_at) begin
      if ($urandom_range(0, 9) < 8) send_expression();
      else send_noise();
      if ($urandom_range(0, 39) == 0) wait_for_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // add wraps max+1 to min; min / -1 stays min without a flag
  task automatic test_arith_extremes();
    send_token(FUNC_PUSH, 32'h7FFF_FFFF);
    send_token(FUNC_PUSH, 32'd1);
    send_token(FUNC_ADD, '0);
    send_token(FUNC_PUSH, '1);
    send_token(FUNC_DIV, '1);
    send_token(FUNC_FINISH, '0);
  endtask

  // min mod -1 is zero; then sub, mul and a negative-divisor div
  task automatic test_sign_handling();
    send_token(FUNC_PUSH, 32'h8000_0000);
    send_token(FUNC_PUSH, '1);
    send_token(FUNC_MOD, '0);
    send_token(FUNC_PUSH, 32'd12);
    send_token(FUNC_SUB, '0);
    send_token(FUNC_PUSH, -32'sd5);
    send_token(FUNC_MUL, '0);
    send_token(FUNC_PUSH, -32'sd7);
    send_token(FUNC_DIV, '0);
    send_token(FUNC_FINISH, '1);
  endtask

  // finish on empty stack, and the reserved code dropped
  task automatic test_empty_and_reserved();
    send_token(FUNC_FINISH, '0);
    send_token(FUNC_RSVD, '1);
    send_token(FUNC_FINISH, '0);
  endtask

  // div by zero latches; later mod by zero and underflow don't replace it
  task automatic test_divide_by_zero();
    send_token(FUNC_PUSH, 32'd5);
    send_token(FUNC_PUSH, '0);
    send_token(FUNC_DIV, '0);
    send_token(FUNC_PUSH, '0);
    send_token(FUNC_MOD, '0);
    send_token(FUNC_ADD, '0);
    send_token(FUNC_FINISH, '0);
  endtask

  // one push past full is dropped and reported as overflow
  task automatic test_stack_overflow();
    int i;
    for (i = 0; i <= DEPTH; i++) send_token(FUNC_PUSH, $urandom());
    send_token(FUNC_FINISH, '0);
  endtask

  task automatic test_random_expressions(input int unsigned count);
    gaps_on   = 1'b1;
    sink_mode = SINK_RANDOM;
    run_token_mix(count);
  endtask

  // no idling on either side
  task automatic test_back_to_back(input int unsigned count);
    gaps_on   = 1'b0;
    sink_mode = SINK_FREE;
    run_token_mix(count);
  endtask

  // long output stalls with a flat-out sender fill the token queue
  task automatic test_output_backpressure(input int unsigned count);
    gaps_on   = 1'b0;
    sink_mode = SINK_HEAVY;
    run_token_mix(count);
  endtask

  initial begin : stimulus
    in_tvalid <= 1'b0;
    in_tuser  <= FUNC_PUSH;
    in_tdata  <= '0;
    rst_n     <= 1'b0;
    calc_sp     = 0;
    calc_err    = STAT_OK;
    tokens_sent = 0;
    fail_count  = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_arith_extremes();
    test_sign_handling();
    test_empty_and_reserved();
    test_divide_by_zero();
    test_stack_overflow();
    wait_for_results();

    test_random_expressions(1500);
    wait_for_results();
    test_back_to_back(200);
    wait_for_results();
    test_output_backpressure(200);

    sink_mode = SINK_RANDOM;
    wait_for_results();
    // catch any stray result past the last expected one
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
